/* rtl/stochastic_reaction_step_unit_macros.svh */
// Assertion helpers for the step unit design file.
`ifndef STOCHASTIC_REACTION_STEP_UNIT_MACROS_SVH
`define STOCHASTIC_REACTION_STEP_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("srs: implication check failed");

// Next-cycle implication, ignored while reset is asserted.
`define SRS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("srs: next-cycle check failed");

`endif

/* rtl/srs_pkg.sv */
package srs_pkg;

  localparam int unsigned NumReact   = 16;
  localparam int unsigned NumSpecies = 16;
  localparam int unsigned NumProd    = 10;
  localparam int unsigned ProdDepth  = NumReact * NumProd;
  localparam int unsigned ProdAddrW  = $clog2(ProdDepth);

  localparam logic [63:0] EpsQ24 = 64'd2;
  localparam logic [31:0] Ln2Q32 = 32'hB172_17F8;

  typedef enum logic [2:0] {
    CMD_LOAD_COUNT = 3'd0,
    CMD_LOAD_HDR   = 3'd1,
    CMD_LOAD_PROD  = 3'd2,
    CMD_STEP       = 3'd3,
    CMD_READ_COUNT = 3'd4,
    CMD_CLEAR_TIME = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NO_RXN  = 2'd1,
    STS_SAT     = 2'd2,
    STS_BAD_IDX = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_REACTIONS = 1'b0,
    REG_SPECIES   = 1'b1
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PROP_RD,
    ST_PROP_MUL1,
    ST_PROP_MUL2,
    ST_CHECK,
    ST_NORM,
    ST_SQR,
    ST_LN1,
    ST_LN2,
    ST_DIV,
    ST_THR1,
    ST_THR2,
    ST_PICK,
    ST_APPLY1,
    ST_APPLY2,
    ST_PROD_RD,
    ST_PROD_WB,
    ST_FINISH
  } state_e;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  // Returns {saturated, new count}.
  function automatic logic [16:0] cnt_add(input logic [15:0] c, input logic [8:0] d);
    logic [17:0] v;
    v = {2'b00, c} + {{9{d[8]}}, d};
    if (v[17]) begin
      return {1'b1, 16'd0};
    end else if (v[16]) begin
      return {1'b1, 16'hFFFF};
    end
    return {1'b0, v[15:0]};
  endfunction

  // Register value 0 counts as 1, values above the maximum as the maximum.
  function automatic logic [4:0] clamp_reg(input logic [4:0] v, input logic [4:0] mx);
    if (v == 5'd0) begin
      return 5'd1;
    end
    return (v > mx) ? mx : v;
  endfunction

endpackage

/* rtl/srs_ram.sv */
module srs_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 160
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/stochastic_reaction_step_unit.sv */
// One Gillespie direct-method step engine.
// Input channel (in_valid_i / in_stall_o) carries one command transaction:
// load count, load reaction header, load product term, step, read count or
// clear time. Every transaction returns exactly one result transaction on the
// output channel (out_valid_o / out_stall_i): status, chosen reaction,
// simulated time after the command and the read count.
// Configuration writes (cfg_valid_i / cfg_ready_o) set reactions_in_use
// (index 0) and species_in_use (index 1); write them only while idle.
// A step walks the nr reactions in use; one that fires then normalizes rand_time
// (shifting out its leading zeros), runs the log and the divider, picks up to the
// fired reaction and applies its product terms. The radix-2 divider and the 32
// log squarings on the one shared 32x32 multiplier dominate a step that fires.
// Throughput: one command at a time; in_stall_o is high while a command works.
// The next command is accepted while the previous result still waits.
// Reset: counts, rate and header tables and time clear to zero, both registers to 1.
// Product term storage is a RAM whose entries carry valid bits cleared at once.
// Receiver stall: a finished result waits in its state until the output
// register frees; the output payload holds while stalled.
`include "stochastic_reaction_step_unit_macros.svh"

module stochastic_reaction_step_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  reaction_index_i,
  input  logic [3:0]  species_index_i,
  input  logic [3:0]  second_reactant_i,
  input  logic [31:0] rate_i,
  input  logic [1:0]  reactant_count_i,
  input  logic [3:0]  product_count_i,
  input  logic [3:0]  product_slot_i,
  input  logic signed [7:0] product_change_i,
  input  logic [15:0] count_value_i,
  input  logic [31:0] rand_time_i,
  input  logic [31:0] rand_pick_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  chosen_reaction_o,
  output logic [63:0] elapsed_time_o,
  output logic [15:0] species_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  import srs_pkg::*;

  // Control state.
  state_e state_q, state_d;
  logic [4:0] rin_q, sin_q;
  logic       out_valid_q, out_valid_d;

  // Latched command fields.
  logic [2:0]  cmd_q;
  logic [3:0]  ri_q, si_q, s2_q, pc_q, ps_q;
  logic [31:0] rate_q, rt_q, rp_q;
  logic [1:0]  rc_q;
  logic [7:0]  chg_q;
  logic [15:0] cv_q;

  // Tables.
  logic [15:0] counts_q [NumSpecies];
  logic [31:0] rates_q  [NumReact];
  logic [9:0]  rx_q     [NumReact];
  logic [3:0]  plen_q   [NumReact];
  logic [63:0] prop_q   [NumReact];
  logic [ProdDepth-1:0] pvalid_q;
  logic [63:0] time_q, time_d, total_q, total_d;

  // Sequencer datapath.
  logic [3:0]  idx_q, idx_d, sel_q, sel_d, pidx_q, pidx_d;
  logic [15:0] n_q, n_d;
  logic [63:0] prod_q, prod_d, thr_q, thr_d, run_q, run_d, quo_q, quo_d, rem_q, rem_d;
  logic [31:0] m_q, m_d, frac_q, frac_d;
  logic [4:0]  sh_q, sh_d;
  logic [5:0]  it_q, it_d;
  logic        sat_q, sat_d;
  logic [1:0]  rstat_q, rstat_d;
  logic [3:0]  rchosen_q, rchosen_d;
  logic [15:0] rcount_q, rcount_d;

  // Output register.
  logic [1:0]  ost_q;
  logic [3:0]  och_q;
  logic [63:0] otime_q;
  logic [15:0] ocnt_q;

  // Write ports of the tables.
  logic        cnt_we;
  logic [3:0]  cnt_wa;
  logic [15:0] cnt_wd;
  logic        hdr_we, prop_we, ram_we, time_we, total_we, rst_time;
  logic [ProdAddrW-1:0] ram_wa, ram_ra;
  logic [11:0] ram_rd;
  logic        ram_vld_q;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // Decode helpers.
  logic [4:0]  nr, ns;
  logic [3:0]  nr_m1, rx_ix, cnt_ra;
  logic [9:0]  rx_cur;
  logic [1:0]  rx_c;
  logic [3:0]  rx_s1, rx_s2;
  logic [15:0] cnt_rd;
  logic [63:0] prop_rd;
  logic [32:0] sq;
  logic [5:0]  lint;
  logic [31:0] lfrac;
  logic [63:0] lnv, run_new;
  logic [64:0] rem_sh;
  logic        div_ge;
  logic [64:0] rem_sub;
  logic [16:0] cadd;
  logic [11:0] term;
  logic        bad;

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign nr    = clamp_reg(rin_q, 5'(NumReact));
  assign ns    = clamp_reg(sin_q, 5'(NumSpecies));
  assign nr_m1 = 4'(nr - 5'd1);

  assign rx_ix  = (state_q == ST_APPLY1 || state_q == ST_APPLY2) ? sel_q : idx_q;
  assign rx_cur = rx_q[rx_ix];
  assign rx_c   = rx_cur[1:0];
  assign rx_s1  = rx_cur[5:2];
  assign rx_s2  = rx_cur[9:6];
  assign cnt_rd = counts_q[cnt_ra];
  assign prop_rd = prop_q[idx_q];
  assign term   = ram_vld_q ? ram_rd : 12'd0;

  assign sq      = mul_p[63:31];
  assign lint    = 6'(sh_q) + 6'd1 - {5'd0, (frac_q != 32'd0)};
  assign lfrac   = ~frac_q + 32'd1;
  assign lnv     = mul_p + {32'd0, prod_q[63:32]};
  assign run_new = sat_add(run_q, prop_rd);
  assign rem_sh  = {rem_q, quo_q[63]};
  assign div_ge  = rem_sh >= {1'b0, total_q};
  assign rem_sub = rem_sh - {1'b0, total_q};

  assign ram_wa = ProdAddrW'(ri_q) * ProdAddrW'(NumProd) + ProdAddrW'(ps_q);
  assign ram_ra = ProdAddrW'(sel_q) * ProdAddrW'(NumProd) + ProdAddrW'(pidx_q);

  srs_ram #(
    .Width(12),
    .Depth(ProdDepth)
  ) u_prod_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_wa),
    .wdata_i({chg_q, si_q}),
    .raddr_i(ram_ra),
    .rdata_o(ram_rd)
  );

  // Count read address follows the operand the current state needs.
  always_comb begin
    case (state_q)
      ST_PROP_RD, ST_APPLY1:   cnt_ra = rx_s1;
      ST_PROP_MUL1, ST_APPLY2: cnt_ra = rx_s2;
      ST_PROD_WB:              cnt_ra = term[3:0];
      default:                 cnt_ra = si_q;
    endcase
  end

  // Sequencer: next state, datapath updates, table writes.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    sel_d     = sel_q;
    pidx_d    = pidx_q;
    n_d       = n_q;
    prod_d    = prod_q;
    thr_d     = thr_q;
    run_d     = run_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    m_d       = m_q;
    frac_d    = frac_q;
    sh_d      = sh_q;
    it_d      = it_q;
    sat_d     = sat_q;
    rstat_d   = rstat_q;
    rchosen_d = rchosen_q;
    rcount_d  = rcount_q;
    time_d    = time_q;
    total_d   = total_q;
    time_we   = 1'b0;
    total_we  = 1'b0;
    rst_time  = 1'b0;
    cnt_we    = 1'b0;
    cnt_wa    = si_q;
    cnt_wd    = cv_q;
    hdr_we    = 1'b0;
    prop_we   = 1'b0;
    ram_we    = 1'b0;
    mul_a     = 32'd0;
    mul_b     = 32'd0;
    cadd      = 17'd0;
    bad       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        rstat_d   = STS_OK;
        rchosen_d = 4'd0;
        rcount_d  = 16'd0;
        state_d   = ST_FINISH;
        case (cmd_q)
          CMD_LOAD_COUNT: begin
            if ({1'b0, si_q} >= ns) begin
              rstat_d = STS_BAD_IDX;
            end else begin
              cnt_we = 1'b1;
            end
          end
          CMD_LOAD_HDR: begin
            bad = (rc_q == 2'd3) || ({1'b0, pc_q} > 5'(NumProd))
               || (rc_q != 2'd0 && {1'b0, si_q} >= ns)
               || (rc_q == 2'd2 && {1'b0, s2_q} >= ns);
            if (bad) begin
              rstat_d = STS_BAD_IDX;
            end else begin
              hdr_we = 1'b1;
            end
          end
          CMD_LOAD_PROD: begin
            if ({1'b0, ps_q} >= 5'(NumProd) || {1'b0, si_q} >= ns) begin
              rstat_d = STS_BAD_IDX;
            end else begin
              ram_we = 1'b1;
            end
          end
          CMD_STEP: begin
            total_d  = 64'd0;
            total_we = 1'b1;
            idx_d    = 4'd0;
            sat_d    = 1'b0;
            state_d  = ST_PROP_RD;
          end
          CMD_READ_COUNT: begin
            if ({1'b0, si_q} >= ns) begin
              rstat_d = STS_BAD_IDX;
            end else begin
              rcount_d = cnt_rd;
            end
          end
          CMD_CLEAR_TIME: begin
            rst_time = 1'b1;
          end
          default: begin
            rstat_d = STS_BAD_IDX;
          end
        endcase
      end

      // Propensity of one reaction: a count read, the reactant product, then the rate product.
      ST_PROP_RD: begin
        n_d     = cnt_rd;
        state_d = ST_PROP_MUL1;
      end

      ST_PROP_MUL1: begin
        mul_a = {16'd0, n_q};
        if (rx_c == 2'd1) begin
          mul_b = 32'd1;
        end else if (rx_s1 == rx_s2) begin
          mul_b = {16'd0, n_q - 16'd1};
        end else begin
          mul_b = {16'd0, cnt_rd};
        end
        prod_d  = (rx_c == 2'd0) ? 64'd1 : mul_p;
        state_d = ST_PROP_MUL2;
      end

      ST_PROP_MUL2: begin
        mul_a    = rates_q[idx_q];
        mul_b    = prod_q[31:0];
        prop_we  = 1'b1;
        total_d  = sat_add(total_q, mul_p);
        total_we = 1'b1;
        if (idx_q == nr_m1) begin
          state_d = ST_CHECK;
        end else begin
          idx_d   = idx_q + 4'd1;
          state_d = ST_PROP_RD;
        end
      end

      ST_CHECK: begin
        if (total_q < EpsQ24) begin
          rstat_d   = STS_NO_RXN;
          rchosen_d = 4'd0;
          rcount_d  = 16'd0;
          state_d   = ST_FINISH;
        end else begin
          m_d     = (rt_q == 32'd0) ? 32'd1 : rt_q;
          sh_d    = 5'd0;
          state_d = ST_NORM;
        end
      end

      // Normalize the random value one bit per cycle.
      ST_NORM: begin
        if (m_q[31]) begin
          it_d    = 6'd0;
          frac_d  = 32'd0;
          state_d = ST_SQR;
        end else begin
          m_d  = {m_q[30:0], 1'b0};
          sh_d = sh_q + 5'd1;
        end
      end

      // One log2 fraction bit per squaring.
      ST_SQR: begin
        mul_a = m_q;
        mul_b = m_q;
        if (sq[32]) begin
          frac_d = frac_q | (32'h8000_0000 >> it_q[4:0]);
          m_d    = sq[32:1];
        end else begin
          m_d    = sq[31:0];
        end
        it_d = it_q + 6'd1;
        if (it_q == 6'd31) begin
          state_d = ST_LN1;
        end
      end

      ST_LN1: begin
        mul_a   = lfrac;
        mul_b   = Ln2Q32;
        prod_d  = mul_p;
        state_d = ST_LN2;
      end

      ST_LN2: begin
        mul_a   = {26'd0, lint};
        mul_b   = Ln2Q32;
        quo_d   = {lnv[39:0], 24'd0};
        rem_d   = 64'd0;
        it_d    = 6'd0;
        state_d = ST_DIV;
      end

      // Restoring divide, one quotient bit per cycle.
      ST_DIV: begin
        rem_d = div_ge ? rem_sub[63:0] : rem_sh[63:0];
        quo_d = {quo_q[62:0], div_ge};
        it_d  = it_q + 6'd1;
        if (it_q == 6'd63) begin
          time_d  = sat_add(time_q, {quo_q[62:0], div_ge});
          time_we = 1'b1;
          state_d = ST_THR1;
        end
      end

      ST_THR1: begin
        mul_a   = rp_q;
        mul_b   = total_q[31:0];
        prod_d  = mul_p;
        state_d = ST_THR2;
      end

      ST_THR2: begin
        mul_a   = rp_q;
        mul_b   = total_q[63:32];
        thr_d   = mul_p + {32'd0, prod_q[63:32]};
        idx_d   = 4'd0;
        run_d   = 64'd0;
        state_d = ST_PICK;
      end

      ST_PICK: begin
        run_d = run_new;
        if (run_new >= thr_q || idx_q == nr_m1) begin
          sel_d   = idx_q;
          state_d = ST_APPLY1;
        end else begin
          idx_d = idx_q + 4'd1;
        end
      end

      ST_APPLY1: begin
        if (rx_c != 2'd0) begin
          cadd   = cnt_add(cnt_rd, 9'h1FF);
          cnt_we = 1'b1;
          cnt_wa = rx_s1;
          cnt_wd = cadd[15:0];
          sat_d  = sat_q | cadd[16];
        end
        state_d = ST_APPLY2;
      end

      ST_APPLY2: begin
        if (rx_c == 2'd2) begin
          cadd   = cnt_add(cnt_rd, 9'h1FF);
          cnt_we = 1'b1;
          cnt_wa = rx_s2;
          cnt_wd = cadd[15:0];
          sat_d  = sat_q | cadd[16];
        end
        pidx_d  = 4'd0;
        state_d = ST_PROD_RD;
      end

      ST_PROD_RD: begin
        if (pidx_q >= plen_q[sel_q]) begin
          rstat_d   = sat_q ? STS_SAT : STS_OK;
          rchosen_d = sel_q;
          rcount_d  = 16'd0;
          state_d   = ST_FINISH;
        end else begin
          state_d = ST_PROD_WB;
        end
      end

      ST_PROD_WB: begin
        cadd    = cnt_add(cnt_rd, {term[11], term[11:4]});
        cnt_we  = 1'b1;
        cnt_wa  = term[3:0];
        cnt_wd  = cadd[15:0];
        sat_d   = sat_q | cadd[16];
        pidx_d  = pidx_q + 4'd1;
        state_d = ST_PROD_RD;
      end

      ST_FINISH: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Control registers and tables with defined reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rin_q       <= 5'd1;
      sin_q       <= 5'd1;
      time_q      <= 64'd0;
      total_q     <= 64'd0;
      pvalid_q    <= '0;
      for (int i = 0; i < NumSpecies; i++) begin
        counts_q[i] <= 16'd0;
      end
      for (int i = 0; i < NumReact; i++) begin
        rates_q[i] <= 32'd0;
        rx_q[i]    <= 10'd0;
        plen_q[i]  <= 4'd0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_REACTIONS) begin
          rin_q <= cfg_data_i;
        end else begin
          sin_q <= cfg_data_i;
        end
      end
      if (rst_time) begin
        time_q <= 64'd0;
      end else if (time_we) begin
        time_q <= time_d;
      end
      if (total_we) begin
        total_q <= total_d;
      end
      if (ram_we) begin
        pvalid_q[ram_wa] <= 1'b1;
      end
      if (cnt_we) begin
        counts_q[cnt_wa] <= cnt_wd;
      end
      if (hdr_we) begin
        rates_q[ri_q] <= rate_q;
        rx_q[ri_q]    <= {(rc_q == 2'd2) ? s2_q : 4'd0,
                          (rc_q != 2'd0) ? si_q : 4'd0, rc_q};
        plen_q[ri_q]  <= pc_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      cmd_q  <= cmd_i;
      ri_q   <= reaction_index_i;
      si_q   <= species_index_i;
      s2_q   <= second_reactant_i;
      rate_q <= rate_i;
      rc_q   <= reactant_count_i;
      pc_q   <= product_count_i;
      ps_q   <= product_slot_i;
      chg_q  <= product_change_i;
      cv_q   <= count_value_i;
      rt_q   <= rand_time_i;
      rp_q   <= rand_pick_i;
    end
    if (prop_we) begin
      prop_q[idx_q] <= mul_p;
    end
    ram_vld_q <= pvalid_q[ram_ra];
    idx_q     <= idx_d;
    sel_q     <= sel_d;
    pidx_q    <= pidx_d;
    n_q       <= n_d;
    prod_q    <= prod_d;
    thr_q     <= thr_d;
    run_q     <= run_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    m_q       <= m_d;
    frac_q    <= frac_d;
    sh_q      <= sh_d;
    it_q      <= it_d;
    sat_q     <= sat_d;
    rstat_q   <= rstat_d;
    rchosen_q <= rchosen_d;
    rcount_q  <= rcount_d;
    // Load the output register when the result leaves the sequencer.
    if (state_q == ST_FINISH && !(out_valid_q && out_stall_i)) begin
      ost_q   <= rstat_q;
      och_q   <= rchosen_q;
      otime_q <= time_q;
      ocnt_q  <= rcount_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = ost_q;
  assign chosen_reaction_o = och_q;
  assign elapsed_time_o    = otime_q;
  assign species_count_o   = ocnt_q;

  `SRS_ASSERT_IMP(a_log_needs_total, clk_i, rst_ni, state_q == ST_NORM, total_q >= EpsQ24)
  `SRS_ASSERT_IMP(a_pick_in_range, clk_i, rst_ni, state_q == ST_PICK, idx_q <= nr_m1)
  `SRS_ASSERT_NXT(a_finish_loads, clk_i, rst_ni, state_q == ST_FINISH && !(out_valid_q && out_stall_i), out_valid_q && state_q == ST_IDLE)

endmodule

/* tb/sv/stochastic_reaction_step_unit_test.sv */
module stochastic_reaction_step_unit_test;
  import srs_pkg::*;

  // One command transaction as the driver presents it.
  typedef struct {
    logic [2:0]        cmd;
    logic [3:0]        rxn;
    logic [3:0]        spc;
    logic [3:0]        spc_b;
    logic [31:0]       rate;
    logic [1:0]        n_reac;
    logic [3:0]        n_prod;
    logic [3:0]        slot;
    logic signed [7:0] delta;
    logic [15:0]       count;
    logic [31:0]       u_time;
    logic [31:0]       u_pick;
  } ssa_cmd_t;

  // One result transaction as the block returns it.
  typedef struct {
    logic [1:0]  status;
    logic [3:0]  chosen;
    logic [63:0] sim_clock;
    logic [15:0] count;
  } ssa_result_t;

  localparam int unsigned StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = '0;
  logic [3:0]  reaction_index_i = '0;
  logic [3:0]  species_index_i = '0;
  logic [3:0]  second_reactant_i = '0;
  logic [31:0] rate_i = '0;
  logic [1:0]  reactant_count_i = '0;
  logic [3:0]  product_count_i = '0;
  logic [3:0]  product_slot_i = '0;
  logic signed [7:0] product_change_i = '0;
  logic [15:0] count_value_i = '0;
  logic [31:0] rand_time_i = 32'd1;
  logic [31:0] rand_pick_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  chosen_reaction_o;
  logic [63:0] elapsed_time_o;
  logic [15:0] species_count_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;

  // Shadow of the engine state, kept in step with every accepted transaction.
  logic [15:0]       mol_count[NumSpecies];
  logic [63:0]       sim_clock_q;
  logic [31:0]       rate_k[NumReact];
  logic [1:0]        reac_n[NumReact];
  logic [3:0]        reac_a[NumReact];
  logic [3:0]        reac_b[NumReact];
  logic [3:0]        prod_len[NumReact];
  logic [3:0]        prod_spc[ProdDepth];
  logic signed [7:0] prod_delta[ProdDepth];
  logic [4:0]        rxn_reg = 5'd1;
  logic [4:0]        spc_reg = 5'd1;

  ssa_result_t pending_results[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int unsigned quiet_cycles = 0;

  stochastic_reaction_step_unit u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Randomly hold off the result channel; a stalled payload must hold.
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < stall_pct);
  end

  // Compare every accepted result against the oldest prediction and watch for hangs.
  always @(posedge clk_i) begin
    ssa_result_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
          || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("stochastic_reaction_step_unit_test failed");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: status %0d", status_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (chosen_reaction_o !== want.chosen) begin
            $error("chosen_reaction: expected %0d, got %0d", want.chosen,
                   chosen_reaction_o);
            mismatches++;
          end
          if (elapsed_time_o !== want.sim_clock) begin
            $error("elapsed_time: expected %h, got %h", want.sim_clock, elapsed_time_o);
            mismatches++;
          end
          if (species_count_o !== want.count) begin
            $error("species_count: expected %0d, got %0d", want.count, species_count_o);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic logic [4:0] effective(input logic [4:0] v, input int unsigned mx);
    if (v == 5'd0) return 5'd1;
    return (v > mx) ? 5'(mx) : v;
  endfunction

  function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Add a signed change to one count, clamp to 0..65535; return 1 when clamped.
  function automatic bit bump_count(input logic [3:0] s, input int d);
    int v;
    v = int'(mol_count[s]) + d;
    if (v < 0) begin
      mol_count[s] = '0;
      return 1'b1;
    end
    if (v > 65535) begin
      mol_count[s] = '1;
      return 1'b1;
    end
    mol_count[s] = 16'(v);
    return 1'b0;
  endfunction

  // -ln(x / 2^32) in unsigned Q.32: log2 by repeated squaring, then scale by ln 2.
  function automatic logic [63:0] neg_log_q32(input logic [31:0] x);
    int          msb;
    logic [63:0] mant, frac, lg;
    if (x == 0) x = 32'd1;
    msb = 31;
    while (!x[msb]) msb--;
    mant = {32'd0, x} << (31 - msb);
    frac = '0;
    for (int i = 0; i < 32; i++) begin
      mant = (mant * mant) >> 31;
      if (mant >= 64'h1_0000_0000) begin
        frac[31 - i] = 1'b1;
        mant = mant >> 1;
      end
    end
    lg = (64'(32 - msb) << 32) - frac;
    return (lg >> 32) * 64'(Ln2Q32) + (((lg & 64'hFFFF_FFFF) * 64'(Ln2Q32)) >> 32);
  endfunction

  // One direct-method step on the shadow state; returns its status.
  function automatic logic [1:0] fire_reaction(input ssa_cmd_t c, output logic [3:0] pick);
    logic [63:0] prop[NumReact];
    logic [63:0] total, k, n, thr, run, dt;
    int          nr, j;
    bit          sat;
    nr = effective(rxn_reg, NumReact);
    total = '0;
    pick = '0;
    for (int i = 0; i < nr; i++) begin
      k = 64'(rate_k[i]);
      n = 64'(mol_count[reac_a[i]]);
      case (reac_n[i])
        2'd0: prop[i] = k;
        2'd1: prop[i] = k * n;
        default: begin
          if (reac_a[i] == reac_b[i]) prop[i] = (n != 0) ? k * n * (n - 1) : '0;
          else prop[i] = k * n * 64'(mol_count[reac_b[i]]);
        end
      endcase
      total = add_sat64(total, prop[i]);
    end
    if (total < EpsQ24) return STS_NO_RXN;
    dt = (neg_log_q32(c.u_time) << 24) / total;
    sim_clock_q = add_sat64(sim_clock_q, dt);
    thr = 64'(c.u_pick) * (total >> 32) + ((64'(c.u_pick) * (total & 64'hFFFF_FFFF)) >> 32);
    j = nr - 1;
    run = '0;
    for (int i = 0; i < nr; i++) begin
      run = add_sat64(run, prop[i]);
      if (run >= thr) begin
        j = i;
        break;
      end
    end
    pick = 4'(j);
    sat = 1'b0;
    if (reac_n[j] >= 1) sat |= bump_count(reac_a[j], -1);
    if (reac_n[j] >= 2) sat |= bump_count(reac_b[j], -1);
    for (int i = 0; i < prod_len[j] && i < NumProd; i++) begin
      sat |= bump_count(prod_spc[j * NumProd + i], int'(prod_delta[j * NumProd + i]));
    end
    return sat ? STS_SAT : STS_OK;
  endfunction

  // Apply one accepted command to the shadow state and predict its result.
  function automatic ssa_result_t predict_reaction_step(input ssa_cmd_t c);
    ssa_result_t r;
    logic [4:0]  ns;
    ns = effective(spc_reg, NumSpecies);
    r.status = STS_OK;
    r.chosen = '0;
    r.count = '0;
    case (c.cmd)
      CMD_LOAD_COUNT: begin
        if (c.spc >= ns) r.status = STS_BAD_IDX;
        else mol_count[c.spc] = c.count;
      end
      CMD_LOAD_HDR: begin
        if (c.n_reac == 2'd3 || c.n_prod > NumProd || (c.n_reac >= 1 && c.spc >= ns)
            || (c.n_reac == 2 && c.spc_b >= ns)) begin
          r.status = STS_BAD_IDX;
        end else begin
          rate_k[c.rxn] = c.rate;
          reac_n[c.rxn] = c.n_reac;
          reac_a[c.rxn] = (c.n_reac >= 1) ? c.spc : 4'd0;
          reac_b[c.rxn] = (c.n_reac >= 2) ? c.spc_b : 4'd0;
          prod_len[c.rxn] = c.n_prod;
        end
      end
      CMD_LOAD_PROD: begin
        if (c.slot >= NumProd || c.spc >= ns) begin
          r.status = STS_BAD_IDX;
        end else begin
          prod_spc[c.rxn * NumProd + c.slot] = c.spc;
          prod_delta[c.rxn * NumProd + c.slot] = c.delta;
        end
      end
      CMD_STEP: r.status = fire_reaction(c, r.chosen);
      CMD_READ_COUNT: begin
        if (c.spc >= ns) r.status = STS_BAD_IDX;
        else r.count = mol_count[c.spc];
      end
      CMD_CLEAR_TIME: sim_clock_q = '0;
      default: r.status = STS_BAD_IDX;
    endcase
    r.sim_clock = sim_clock_q;
    return r;
  endfunction

  // Present one command, hold it until accepted, record its prediction.
  task automatic send_command(input ssa_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    cmd_i = c.cmd;
    reaction_index_i = c.rxn;
    species_index_i = c.spc;
    second_reactant_i = c.spc_b;
    rate_i = c.rate;
    reactant_count_i = c.n_reac;
    product_count_i = c.n_prod;
    product_slot_i = c.slot;
    product_change_i = c.delta;
    count_value_i = c.count;
    rand_time_i = c.u_time;
    rand_pick_i = c.u_pick;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_reaction_step(c));
    @(negedge clk_i);
  endtask

  function automatic ssa_cmd_t blank_cmd(input logic [2:0] cmd);
    ssa_cmd_t c;
    c = '{cmd: cmd, rxn: 4'd0, spc: 4'd0, spc_b: 4'd0, rate: 32'd0, n_reac: 2'd0,
          n_prod: 4'd0, slot: 4'd0, delta: 8'sd0, count: 16'd0, u_time: 32'd1,
          u_pick: 32'd0};
    return c;
  endfunction

  task automatic load_count(input logic [3:0] s, input logic [15:0] v);
    ssa_cmd_t c;
    c = blank_cmd(CMD_LOAD_COUNT);
    c.spc = s;
    c.count = v;
    send_command(c);
  endtask

  task automatic load_header(input logic [3:0] r, input logic [31:0] k, input logic [1:0] nr,
                             input logic [3:0] a, input logic [3:0] b, input logic [3:0] np);
    ssa_cmd_t c;
    c = blank_cmd(CMD_LOAD_HDR);
    c.rxn = r;
    c.rate = k;
    c.n_reac = nr;
    c.spc = a;
    c.spc_b = b;
    c.n_prod = np;
    send_command(c);
  endtask

  task automatic load_product(input logic [3:0] r, input logic [3:0] sl, input logic [3:0] s,
                              input logic signed [7:0] d);
    ssa_cmd_t c;
    c = blank_cmd(CMD_LOAD_PROD);
    c.rxn = r;
    c.slot = sl;
    c.spc = s;
    c.delta = d;
    send_command(c);
  endtask

  task automatic step_once(input logic [31:0] ut, input logic [31:0] up);
    ssa_cmd_t c;
    c = blank_cmd(CMD_STEP);
    c.u_time = ut;
    c.u_pick = up;
    send_command(c);
  endtask

  task automatic read_count(input logic [3:0] s);
    ssa_cmd_t c;
    c = blank_cmd(CMD_READ_COUNT);
    c.spc = s;
    send_command(c);
  endtask

  // Hold the sender until every pending result is back and the engine is quiet.
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Write one register while the engine is idle.
  task automatic write_register(input reg_e idx, input logic [4:0] v);
    drain_results();
    cfg_index_i = idx;
    cfg_data_i = v;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_REACTIONS) rxn_reg = v;
    else spc_reg = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Reset state: empty tables, one species, nothing can fire, unknown opcodes.
  task automatic test_reset_state();
    read_count(4'd0);
    read_count(4'd1);
    step_once(32'd0, 32'd0);
    send_command(blank_cmd(3'd6));
    send_command(blank_cmd(3'd7));
  endtask

  // Loads at the table edges and bad indices for each load and the read command.
  task automatic test_table_loads();
    write_register(REG_SPECIES, 5'd16);
    load_count(4'd15, 16'hFFFF);
    load_count(4'd0, 16'd1);
    load_header(4'd3, 32'h0100_0000, 2'd3, 4'd0, 4'd0, 4'd1);
    load_header(4'd3, 32'h0100_0000, 2'd1, 4'd0, 4'd0, 4'd11);
    load_product(4'd3, 4'd10, 4'd0, 8'sd1);
    write_register(REG_SPECIES, 5'd4);
    load_count(4'd4, 16'd9);
    load_header(4'd3, 32'h0100_0000, 2'd2, 4'd1, 4'd4, 4'd1);
    read_count(4'd15);
    write_register(REG_SPECIES, 5'd16);
    read_count(4'd15);
  endtask

  // Steps with saturating products, zero random time and extreme picks.
  task automatic test_step_cases();
    write_register(REG_REACTIONS, 5'd2);
    load_header(4'd0, 32'h0100_0000, 2'd1, 4'd0, 4'd0, 4'd1);
    load_product(4'd0, 4'd0, 4'd15, 8'sd127);
    load_header(4'd1, 32'hFFFF_FFFF, 2'd2, 4'd1, 4'd2, 4'd10);
    load_product(4'd1, 4'd9, 4'd2, -8'sd128);
    load_count(4'd1, 16'd5);
    load_count(4'd2, 16'd3);
    step_once(32'd0, 32'd0);
    step_once(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    step_once(32'h8000_0000, 32'h0000_0001);
    send_command(blank_cmd(CMD_CLEAR_TIME));
  endtask

  // Tiny total propensity and minimal random time drive the clock to saturation.
  task automatic test_time_saturation();
    write_register(REG_REACTIONS, 5'd0);
    load_header(4'd0, 32'd1, 2'd0, 4'd0, 4'd0, 4'd0);
    step_once(32'd1, 32'd0);
    load_header(4'd0, 32'd2, 2'd0, 4'd0, 4'd0, 4'd0);
    repeat (28) step_once(32'd0, $urandom());
    send_command(blank_cmd(CMD_CLEAR_TIME));
  endtask

  function automatic ssa_cmd_t random_cmd();
    ssa_cmd_t    c;
    int          sel;
    logic [4:0]  ns;
    ns = effective(spc_reg, NumSpecies);
    sel = $urandom_range(99);
    c.cmd = (sel < 14) ? CMD_LOAD_COUNT : (sel < 28) ? CMD_LOAD_HDR :
            (sel < 44) ? CMD_LOAD_PROD : (sel < 82) ? CMD_STEP :
            (sel < 93) ? CMD_READ_COUNT : (sel < 96) ? CMD_CLEAR_TIME :
            3'($urandom_range(6, 7));
    c.rxn = 4'($urandom());
    c.spc = ($urandom_range(9) == 0) ? 4'($urandom()) : 4'($urandom_range(ns - 1));
    c.spc_b = ($urandom_range(9) == 0) ? 4'($urandom()) : 4'($urandom_range(ns - 1));
    c.rate = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(32'h0400_0000));
    c.n_reac = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2));
    c.n_prod = ($urandom_range(9) == 0) ? 4'($urandom()) : 4'($urandom_range(4));
    c.slot = ($urandom_range(9) == 0) ? 4'($urandom()) : 4'($urandom_range(NumProd - 1));
    c.delta = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(6) - 3);
    c.count = ($urandom_range(4) == 0) ? 16'($urandom()) : 16'($urandom_range(40));
    c.u_time = $urandom();
    c.u_pick = $urandom();
    return c;
  endfunction

  // Mixed traffic across several register settings under each idling pattern.
  task automatic test_random_traffic();
    int sender_pct[3] = '{6, 52, 0};
    int stalls_pct[3] = '{52, 6, 0};
    for (int mode = 0; mode < 3; mode++) begin
      for (int ph = 0; ph < 3; ph++) begin
        write_register(REG_REACTIONS, (ph == 0) ? 5'd16 : 5'($urandom()));
        write_register(REG_SPECIES, (ph == 1) ? 5'd31 : 5'($urandom_range(1, 16)));
        send_idle_pct = sender_pct[mode];
        stall_pct = stalls_pct[mode];
        repeat (100) send_command(random_cmd());
      end
    end
  endtask

  initial begin
    foreach (mol_count[i]) mol_count[i] = '0;
    foreach (rate_k[i]) begin
      rate_k[i] = '0;
      reac_n[i] = '0;
      reac_a[i] = '0;
      reac_b[i] = '0;
      prod_len[i] = '0;
    end
    foreach (prod_spc[i]) begin
      prod_spc[i] = '0;
      prod_delta[i] = '0;
    end
    sim_clock_q = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_table_loads();
    test_step_cases();
    test_time_saturation();
    test_random_traffic();

    // Drain, then wait for stray results.
    drain_results();
    repeat (400) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("stochastic_reaction_step_unit_test passed");
    end else begin
      $display("stochastic_reaction_step_unit_test failed");
    end
    $finish;
  end

endmodule
